[src/owq_pkg.sv]
// Package for the ordered wait queue: sizes, command and status codes,
// entry and control types. No dependencies.
package owq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned ID_BITS = 16;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ID_W    = 16;
  localparam int unsigned OCC_W   = 5;

  typedef enum logic [1:0] {
    CMD_PUSH      = 2'd0,
    CMD_POP_HEAD  = 2'd1,
    CMD_POP_TAIL  = 2'd2,
    CMD_REMOVE_ID = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic               kind;
    logic [ID_BITS-1:0] id;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e          status;
    entry_t           removed;
    logic [CNT_W-1:0] fill;
    logic             head_valid;
    entry_t           head;
  } result_t;

endpackage

[src/owq_mem.sv]
// Slot storage of the wait queue: one write port, one registered read port.
// Depends on owq_pkg.
module owq_mem (
  input  logic              clk_i,
  input  owq_pkg::mem_req_t req_i,
  output owq_pkg::entry_t   rd_data_o
);

  owq_pkg::entry_t mem_q [owq_pkg::DEPTH];
  owq_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_data_q <= mem_q[req_i.raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/owq_seq.sv]
// Command sequencer: scans, compares and compacts the slots one per cycle
// through the slot memory's write and read port. Depends on owq_pkg.
module owq_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  owq_pkg::cmd_e     cmd_i,
  input  logic              push_kind_i,
  input  logic [owq_pkg::ID_BITS-1:0] tid_i,
  input  logic              res_free_i,
  output logic              res_valid_o,
  output owq_pkg::result_t  res_o,
  output owq_pkg::mem_req_t mem_req_o,
  input  owq_pkg::entry_t   rd_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_TAKE  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_HEAD  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int unsigned IW = owq_pkg::IDX_W;
  localparam int unsigned CW = owq_pkg::CNT_W;

  logic [2:0]               state_q, state_d;
  owq_pkg::cmd_e            cmd_q, cmd_d;
  logic [owq_pkg::ID_BITS-1:0] tid_q, tid_d;
  logic [IW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            fill_q, fill_d;
  owq_pkg::status_e         status_q, status_d;
  owq_pkg::entry_t          rem_q, rem_d;

  logic                     start_shift;
  logic [IW-1:0]            shift_pos;
  logic                     accept;

  assign accept = cmd_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    tid_d       = tid_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    status_d    = status_q;
    rem_d       = rem_q;
    start_shift = 1'b0;
    shift_pos   = '0;
    mem_req_o   = '0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_i;
          tid_d    = tid_i;
          status_d = owq_pkg::ST_OK;
          rem_d    = '0;
          case (cmd_i)
            owq_pkg::CMD_PUSH: begin
              if (fill_q == CW'(owq_pkg::DEPTH)) begin
                status_d = owq_pkg::ST_FULL;
              end else begin
                mem_req_o.we         = 1'b1;
                mem_req_o.waddr      = IW'(fill_q);
                mem_req_o.wdata.kind = push_kind_i;
                mem_req_o.wdata.id   = tid_i;
                fill_d               = fill_q + CW'(1);
              end
              state_d = S_HEAD;
            end
            owq_pkg::CMD_POP_HEAD, owq_pkg::CMD_POP_TAIL: begin
              if (fill_q == '0) begin
                status_d = owq_pkg::ST_EMPTY;
                state_d  = S_HEAD;
              end else begin
                mem_req_o.raddr = (cmd_i == owq_pkg::CMD_POP_HEAD) ? '0
                                                                   : IW'(fill_q - CW'(1));
                state_d = S_TAKE;
              end
            end
            owq_pkg::CMD_REMOVE_ID: begin
              if (fill_q == '0) begin
                status_d = owq_pkg::ST_NOTFOUND;
                state_d  = S_HEAD;
              end else begin
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: state_d = S_HEAD;
          endcase
        end
      end
      S_SCAN: begin
        // Compare the slot under idx while fetching the next one.
        if (rd_data_i.id == tid_q) begin
          rem_d       = rd_data_i;
          start_shift = 1'b1;
          shift_pos   = idx_q;
        end else if (CW'(idx_q) + CW'(1) == fill_q) begin
          status_d = owq_pkg::ST_NOTFOUND;
          state_d  = S_HEAD;
        end else begin
          idx_d           = idx_q + IW'(1);
          mem_req_o.raddr = idx_q + IW'(1);
        end
      end
      S_TAKE: begin
        rem_d = rd_data_i;
        if (cmd_q == owq_pkg::CMD_POP_TAIL) begin
          fill_d  = fill_q - CW'(1);
          state_d = S_HEAD;
        end else begin
          start_shift = 1'b1;
          shift_pos   = '0;
        end
      end
      S_SHIFT: begin
        // Move slot idx+1 up to idx, fetch idx+2 for the next cycle.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = rd_data_i;
        if (CW'(idx_q) + CW'(2) == fill_q) begin
          fill_d  = fill_q - CW'(1);
          state_d = S_HEAD;
        end else begin
          idx_d           = idx_q + IW'(1);
          mem_req_o.raddr = idx_q + IW'(2);
        end
      end
      S_HEAD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (start_shift) begin
      if (CW'(shift_pos) + CW'(1) == fill_q) begin
        fill_d  = fill_q - CW'(1);
        state_d = S_HEAD;
      end else begin
        idx_d           = shift_pos;
        mem_req_o.raddr = shift_pos + IW'(1);
        state_d         = S_SHIFT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    tid_q    <= tid_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    rem_q    <= rem_d;
  end

  assign cmd_ready_o        = (state_q == S_IDLE);
  assign res_o.status       = status_q;
  assign res_o.removed      = rem_q;
  assign res_o.fill         = fill_q;
  assign res_o.head_valid   = (fill_q != '0);
  assign res_o.head         = (fill_q != '0) ? rd_data_i : '0;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(owq_pkg::DEPTH))
    else $error("fill count above depth");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (CW'(idx_q) + CW'(2) <= fill_q))
    else $error("compaction past the tail");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> (fill_q == $past(fill_q)) ||
                            (fill_q + CW'(1) == $past(fill_q)))
    else $error("fill changed by more than one during a command");

endmodule

[src/ordered_wait_queue_with_removal_unit.sv]
// Top level of the ordered wait queue with removal by id: sequencer, slot
// memory and result register. Depends on owq_pkg, owq_mem, owq_seq.
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_ready_o   cmd_i, push_kind_i, thread_id_i
//  out      source     out_valid_o / out_ready_i status_o, removed_*_o,
//                                                occupancy_o, head_*_o
//
// One item at a time through the slot memory. A pop reads its slot, a remove
// by id scans for it; a pop of the head or a hit on a remove then compacts the
// slots behind it. Scan and compaction move one slot per cycle.
// Reset clears the fill count and control state only; slots are never read
// beyond the fill count. A finished item waits in the result register; the
// sequencer holds the next result, and its input, until that register frees.
module ordered_wait_queue_with_removal_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic        push_kind_i,
  input  logic [15:0] thread_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        removed_kind_o,
  output logic [15:0] removed_id_o,
  output logic [4:0]  occupancy_o,
  output logic        head_valid_o,
  output logic        head_kind_o,
  output logic [15:0] head_id_o
);

  owq_pkg::mem_req_t mem_req;
  owq_pkg::entry_t   rd_data;
  owq_pkg::result_t  res;
  logic              res_valid;
  logic              res_free;
  logic              out_valid_q;
  owq_pkg::result_t  out_q;

  // Free when empty or being drained this cycle.
  assign res_free = !out_valid_q || out_ready_i;

  owq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_valid_i),
    .cmd_ready_o (in_ready_o),
    .cmd_i       (owq_pkg::cmd_e'(cmd_i)),
    .push_kind_i (push_kind_i),
    .tid_i       (owq_pkg::ID_BITS'(thread_id_i)),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  owq_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Hold the result until taken; load a new one when the register frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign removed_kind_o = out_q.removed.kind;
  assign removed_id_o   = owq_pkg::ID_W'(out_q.removed.id);
  assign occupancy_o    = owq_pkg::OCC_W'(out_q.fill);
  assign head_valid_o   = out_q.head_valid;
  assign head_kind_o    = out_q.head.kind;
  assign head_id_o      = owq_pkg::ID_W'(out_q.head.id);

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == owq_pkg::ST_FULL)) |->
      (out_q.fill == owq_pkg::CNT_W'(owq_pkg::DEPTH)))
    else $error("full status with free slots");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == owq_pkg::ST_EMPTY)) |->
      (out_q.fill == '0) && !head_valid_o)
    else $error("empty status with entries");

  a_no_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != owq_pkg::ST_OK)) |->
      (!removed_kind_o && (removed_id_o == '0)))
    else $error("removed entry reported on failure");

  a_head_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_valid_o == (out_q.fill != '0)))
    else $error("head valid disagrees with occupancy");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the ordered wait queue with removal by id.
// Drives commands through valid/ready, predicts each result in a local queue model.
// Depends on owq_pkg and ordered_wait_queue_with_removal_unit.
`timescale 1ns / 100ps

module tb;

  localparam int CLK_PERIOD = 8;
  localparam int RAND_ITEMS = 1625;
  localparam int RX_HOLD    = 300;        // long receiver hold-off, in cycles
  localparam int QUIET_MAX  = 4000;       // cycles with no handshake before giving up
  localparam int TAIL_WAIT  = 2 * owq_pkg::DEPTH + 8;

  // One expected result item, field by field at the port widths.
  typedef struct packed {
    owq_pkg::status_e status;
    logic             rkind;
    logic [15:0]      rid;
    logic [4:0]       occ;
    logic             hvalid;
    logic             hkind;
    logic [15:0]      hid;
  } qresult_t;

  typedef struct packed {
    owq_pkg::cmd_e cmd;
    logic          kind;
    logic [15:0]   tid;
    logic          pinned;   // expectation typed in below instead of predicted
    qresult_t      want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic        push_kind;
  logic [15:0] thread_id;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic        removed_kind;
  logic [15:0] removed_id;
  logic [4:0]  occupancy;
  logic        head_valid;
  logic        head_kind;
  logic [15:0] head_id;

  // Local copy of the wait queue: head at slot 0, compacted.
  logic                        wq_kind [owq_pkg::DEPTH];
  logic [owq_pkg::ID_BITS-1:0] wq_id   [owq_pkg::DEPTH];
  int                          wq_fill = 0;

  qresult_t  pending_results[$];
  stim_row_t dir_rows[$];
  int        fail_count   = 0;
  int        quiet_cycles = 0;
  bit        rx_hold_req  = 1'b0;

  ordered_wait_queue_with_removal_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .push_kind_i   (push_kind),
    .thread_id_i   (thread_id),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .removed_kind_o(removed_kind),
    .removed_id_o  (removed_id),
    .occupancy_o   (occupancy),
    .head_valid_o  (head_valid),
    .head_kind_o   (head_kind),
    .head_id_o     (head_id)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Apply one command to the local queue and return the result it must give.
  function automatic qresult_t apply_command(owq_pkg::cmd_e c, logic k, logic [15:0] tid);
    qresult_t                    r;
    logic [owq_pkg::ID_BITS-1:0] key;
    int                          hit;
    key      = tid[owq_pkg::ID_BITS-1:0];
    r        = '0;
    r.status = owq_pkg::ST_OK;
    hit      = -1;
    case (c)
      owq_pkg::CMD_PUSH: begin
        if (wq_fill >= owq_pkg::DEPTH) begin
          r.status = owq_pkg::ST_FULL;          // drop the entry, keep the state
        end else begin
          wq_kind[wq_fill] = k;
          wq_id[wq_fill]   = key;
          wq_fill++;
        end
      end
      owq_pkg::CMD_POP_HEAD: begin
        if (wq_fill == 0) r.status = owq_pkg::ST_EMPTY;
        else hit = 0;
      end
      owq_pkg::CMD_POP_TAIL: begin
        if (wq_fill == 0) r.status = owq_pkg::ST_EMPTY;
        else hit = wq_fill - 1;
      end
      default: begin
        // first match counted from the head wins
        r.status = owq_pkg::ST_NOTFOUND;
        for (int i = 0; i < wq_fill; i++) begin
          if (wq_id[i] == key) begin
            hit      = i;
            r.status = owq_pkg::ST_OK;
            break;
          end
        end
      end
    endcase
    if (hit >= 0) begin
      r.rkind = wq_kind[hit];
      r.rid   = 16'(wq_id[hit]);
      // close the gap: everything behind moves up one slot
      for (int i = hit; i + 1 < wq_fill; i++) begin
        wq_kind[i] = wq_kind[i + 1];
        wq_id[i]   = wq_id[i + 1];
      end
      wq_fill--;
    end
    r.occ = 5'(wq_fill);
    if (wq_fill > 0) begin
      r.hvalid = 1'b1;
      r.hkind  = wq_kind[0];
      r.hid    = 16'(wq_id[0]);
    end
    return r;
  endfunction

  function automatic void add_row(owq_pkg::cmd_e c, logic k, logic [15:0] tid);
    stim_row_t row;
    row        = '0;
    row.cmd    = c;
    row.kind   = k;
    row.tid    = tid;
    dir_rows.push_back(row);
  endfunction

  // Rows whose result is obvious: nothing removed, head and fill given.
  function automatic void add_pinned(owq_pkg::cmd_e c, logic k, logic [15:0] tid,
                                     owq_pkg::status_e st, int occ, logic hk,
                                     logic [15:0] hid);
    stim_row_t row;
    row             = '0;
    row.cmd         = c;
    row.kind        = k;
    row.tid         = tid;
    row.pinned      = 1'b1;
    row.want.status = st;
    row.want.occ    = 5'(occ);
    row.want.hvalid = (occ != 0);
    row.want.hkind  = hk;
    row.want.hid    = hid;
    dir_rows.push_back(row);
  endfunction

  // Present one item, hold it until accepted, return the predicted result.
  task automatic offer_item(input owq_pkg::cmd_e c, input logic k, input logic [15:0] tid,
                            output qresult_t pred);
    in_valid  <= 1'b1;
    cmd       <= c;
    push_kind <= k;
    thread_id <= tid;
    do @(posedge clk); while (!in_ready);
    pred = apply_command(c, k, tid);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // Result side: compare each accepted item with the oldest expectation.
  // Also count cycles with no handshake on either side for the watchdog.
  always @(posedge clk) begin : result_monitor
    qresult_t want;
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t ns: result with none expected, status %0h occupancy %0d",
                 $time, status, occupancy);
      end else begin
        want = pending_results.pop_front();
        check_field("status",       want.status, status);
        check_field("removed_kind", want.rkind,  removed_kind);
        check_field("removed_id",   want.rid,    removed_id);
        check_field("occupancy",    want.occ,    occupancy);
        check_field("head_valid",   want.hvalid, head_valid);
        check_field("head_kind",    want.hkind,  head_kind);
        check_field("head_id",      want.hid,    head_id);
      end
    end
  end

  // Receiver: random ready pattern, with one long hold-off on request.
  initial begin : result_sink
    int run;
    int r;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        // hold off long enough that the block fills and stalls its input
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        for (run = 0; run < RX_HOLD; run++) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_ready <= 1'b1;
          run = $urandom_range(1, 8);
        end else if (r < 85) begin
          out_ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_ready <= 1'b1;              // stretch with no stalls
          run = $urandom_range(30, 120);
        end else begin
          out_ready <= 1'b0;
          run = $urandom_range(15, 50);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("%0t ns: no handshake for %0d cycles", $time, QUIET_MAX);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    qresult_t      pred;
    stim_row_t     row;
    owq_pkg::cmd_e c;
    logic          k;
    logic [15:0]   tid;
    int            fill_goal;
    int            goal_until;
    int            r;
    int            gap;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    cmd       <= owq_pkg::CMD_PUSH;
    push_kind <= 1'b0;
    thread_id <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty-queue errors, fill to the top with extreme and
    // duplicate ids, push on full, then every kind of removal.
    add_pinned(owq_pkg::CMD_POP_HEAD,  1'b0, 16'h0000, owq_pkg::ST_EMPTY,
               0, 1'b0, 16'h0000);
    add_pinned(owq_pkg::CMD_POP_TAIL,  1'b1, 16'hffff, owq_pkg::ST_EMPTY,
               0, 1'b0, 16'h0000);
    add_pinned(owq_pkg::CMD_REMOVE_ID, 1'b0, 16'hffff, owq_pkg::ST_NOTFOUND,
               0, 1'b0, 16'h0000);
    add_pinned(owq_pkg::CMD_PUSH,      1'b0, 16'h0000, owq_pkg::ST_OK,
               1, 1'b0, 16'h0000);
    for (int i = 1; i < owq_pkg::DEPTH; i++)
      add_pinned(owq_pkg::CMD_PUSH, i[0], (i == 1 || i == 6) ? 16'hffff : 16'h1 << i,
                 owq_pkg::ST_OK, i + 1, 1'b0, 16'h0000);
    add_pinned(owq_pkg::CMD_PUSH, 1'b1, 16'h7777, owq_pkg::ST_FULL, owq_pkg::DEPTH,
               1'b0, 16'h0000);
    add_row(owq_pkg::CMD_REMOVE_ID, 1'b0, 16'hffff);   // duplicate: take the one nearest the head
    add_row(owq_pkg::CMD_REMOVE_ID, 1'b1, 16'hffff);   // then the second copy
    add_row(owq_pkg::CMD_REMOVE_ID, 1'b0, 16'h1234);   // absent from a non-empty queue
    add_row(owq_pkg::CMD_POP_TAIL,  1'b0, 16'h0000);
    add_row(owq_pkg::CMD_POP_HEAD,  1'b1, 16'hffff);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      offer_item(row.cmd, row.kind, row.tid, pred);
      pending_results.push_back(row.pinned ? row.want : pred);
      idle_sender(sender_gap());
    end
    drain_results();

    // Random part: steer the fill toward a moving goal so the queue swings
    // between empty and full, with some fully random noise on top.
    fill_goal  = owq_pkg::DEPTH;
    goal_until = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 400 || n == 1200) rx_hold_req = 1'b1;
      if (n == 800) drain_results();
      if (n >= goal_until) begin
        r = $urandom_range(0, 2);
        fill_goal  = (r == 0) ? 0 : (r == 1) ? owq_pkg::DEPTH
                                             : $urandom_range(1, owq_pkg::DEPTH - 1);
        goal_until = n + $urandom_range(20, 80);
      end

      r   = $urandom_range(0, 99);
      k   = 1'($urandom_range(0, 1));
      tid = 16'($urandom_range(0, 65535));
      if (r < 10) begin
        c = owq_pkg::cmd_e'($urandom_range(0, 3));
      end else if (wq_fill < fill_goal || (wq_fill == owq_pkg::DEPTH && r < 55)) begin
        c = owq_pkg::CMD_PUSH;
      end else if (wq_fill > fill_goal || fill_goal == 0 || r < 55) begin
        r = $urandom_range(0, 2);
        c = (r == 0) ? owq_pkg::CMD_POP_HEAD
                     : (r == 1) ? owq_pkg::CMD_POP_TAIL : owq_pkg::CMD_REMOVE_ID;
      end else begin
        c = owq_pkg::cmd_e'($urandom_range(0, 3));
      end

      // small ids make duplicates; removals mostly aim at a live entry
      if (c == owq_pkg::CMD_PUSH && $urandom_range(0, 2) == 0)
        tid = 16'($urandom_range(0, 15));
      if (c == owq_pkg::CMD_REMOVE_ID && wq_fill > 0 && $urandom_range(0, 3) != 0)
        tid = 16'(wq_id[$urandom_range(0, wq_fill - 1)]);

      offer_item(c, k, tid, pred);
      pending_results.push_back(pred);
      gap = (n >= 600 && n < 750) ? 0 : sender_gap();
      idle_sender(gap);
    end

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
